// File: sv/tdjq_pkg.sv
// ============================================================================
// Touch drag joystick qualifier package
// Shared widths, register indexes, reset values and interface types.
// ============================================================================
package tdjq_pkg;

    localparam int COORD_BITS      = 12;
    localparam int ALPHA_FRAC_BITS = 8;
    localparam int ALPHA_W         = ALPHA_FRAC_BITS + 1;
    localparam int SMOOTH_W        = COORD_BITS + ALPHA_FRAC_BITS;
    localparam int Q14_BITS        = 14;
    localparam int MOVE_W          = 16;
    localparam int Q_SHIFT         = Q14_BITS - ALPHA_FRAC_BITS;
    localparam int DIVD_W          = SMOOTH_W + Q_SHIFT;
    localparam int DIV_CNT_W       = $clog2(DIVD_W + 1);
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = (COORD_BITS > ALPHA_W) ? COORD_BITS : ALPHA_W;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << ALPHA_FRAC_BITS);
    localparam logic [DIVD_W-1:0]  Q14_ONE   = DIVD_W'(1 << Q14_BITS);

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLICK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REARM    = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [ALPHA_W-1:0]    ALPHA_RST    = ALPHA_W'(64);
    localparam logic [COORD_BITS-1:0] DEAD_RST     = COORD_BITS'(8);
    localparam logic [COORD_BITS-1:0] SPAN_RST     = COORD_BITS'(40);
    localparam logic [COORD_BITS-1:0] FLICK_RST    = COORD_BITS'(30);
    localparam logic [COORD_BITS-1:0] VELOCITY_RST = COORD_BITS'(12);
    localparam logic [COORD_BITS-1:0] REARM_RST    = COORD_BITS'(10);

    typedef struct packed {
        logic [ALPHA_W-1:0]    alpha;
        logic [COORD_BITS-1:0] dead_zone;
        logic [COORD_BITS-1:0] span;
        logic [COORD_BITS-1:0] flick;
        logic [COORD_BITS-1:0] velocity;
        logic [COORD_BITS-1:0] rearm;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: sv/tdjq_cfg.sv
// ============================================================================
// Configuration register file
// Holds the six tuning registers, written through the configuration port.
// ============================================================================
module tdjq_cfg
    import tdjq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg_out
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ALPHA:    cfg_next.alpha     = cfg_data[ALPHA_W-1:0];
                CFG_DEAD:     cfg_next.dead_zone = cfg_data[COORD_BITS-1:0];
                CFG_SPAN:     cfg_next.span      = cfg_data[COORD_BITS-1:0];
                CFG_FLICK:    cfg_next.flick     = cfg_data[COORD_BITS-1:0];
                CFG_VELOCITY: cfg_next.velocity  = cfg_data[COORD_BITS-1:0];
                CFG_REARM:    cfg_next.rearm     = cfg_data[COORD_BITS-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alpha     <= ALPHA_RST;
            cfg_reg.dead_zone <= DEAD_RST;
            cfg_reg.span      <= SPAN_RST;
            cfg_reg.flick     <= FLICK_RST;
            cfg_reg.velocity  <= VELOCITY_RST;
            cfg_reg.rearm     <= REARM_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_out = cfg_reg;

endmodule

// File: sv/tdjq_div.sv
// ============================================================================
// Serial restoring divider
// Unsigned shift-subtract divider, one quotient bit per cycle.
// ============================================================================
module tdjq_div
    import tdjq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVD_W-1:0]     dividend,
    input  logic [COORD_BITS-1:0] divisor,
    output div_stat_t             stat,
    output logic [DIVD_W-1:0]     quotient
);

    logic [DIVD_W-1:0]     quo_reg, quo_next;
    logic [COORD_BITS-1:0] rem_reg, rem_next;
    logic [COORD_BITS-1:0] dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [COORD_BITS:0]   shifted;
    logic [COORD_BITS+1:0] trial;

    always_comb begin
        shifted   = {rem_reg, quo_reg[DIVD_W-1]};
        trial     = {1'b0, shifted} - {2'b00, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = DIV_CNT_W'(DIVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // A borrow means the trial subtraction failed; keep the shifted remainder.
            if (trial[COORD_BITS+1]) begin
                rem_next = shifted[COORD_BITS-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end else begin
                rem_next = trial[COORD_BITS-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// File: sv/touch_drag_joystick_qualifier_top.sv
// ============================================================================
// Touch drag joystick qualifier
// Turns touch samples into a saturated horizontal deflection and a jump pulse.
// ============================================================================
//  Channel   Direction  Handshake              Payload
//  s_        in         s_valid / s_ready      touch_present, sample_x, sample_y
//  m_        out        m_valid / m_ready      move_x, jump_pulse, touch_active
//  cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  A held-touch sample outside the dead zone passes from acceptance through
//  smoothing (ST_CALC), the dead zone (ST_DZ), the serial divider (ST_DIV, one
//  quotient bit per cycle plus its done strobe) and the output load (ST_FIN).
//  Other samples skip the divider. The next sample is taken once the result is
//  in the output register; a stalled output holds the block. Reset is
//  synchronous on aresetn and needs no clearing time.
// ============================================================================
module touch_drag_joystick_qualifier_top
    import tdjq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_touch_present,
    input  logic [COORD_BITS-1:0] s_sample_x,
    input  logic [COORD_BITS-1:0] s_sample_y,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [MOVE_W-1:0]     m_move_x,
    output logic                  m_jump_pulse,
    output logic                  m_touch_active,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CALC = 3'd1;
    localparam logic [2:0] ST_DZ   = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    cfg_t      cfg;
    div_stat_t div_stat;
    logic [DIVD_W-1:0] div_quo;
    logic              div_start;
    logic [DIVD_W-1:0] div_dividend;

    logic [2:0]              state_reg, state_next;
    logic                    touch_reg, touch_next;
    logic [COORD_BITS-1:0]   x_reg, x_next;
    logic [COORD_BITS-1:0]   y_reg, y_next;
    logic                    was_reg, was_next;
    logic [COORD_BITS-1:0]   anchor_x_reg, anchor_x_next;
    logic [COORD_BITS-1:0]   anchor_y_reg, anchor_y_next;
    logic [SMOOTH_W-1:0]     smooth_reg, smooth_next;
    logic [COORD_BITS-1:0]   last_y_reg, last_y_next;
    logic [COORD_BITS-1:0]   prior_y_reg, prior_y_next;
    logic                    armed_reg, armed_next;
    logic                    held_reg, held_next;
    logic                    jump_reg, jump_next;
    logic                    neg_reg, neg_next;
    logic                    zero_reg, zero_next;
    logic                    m_valid_reg, m_valid_next;
    logic [MOVE_W-1:0]       m_move_reg, m_move_next;
    logic                    m_jump_reg, m_jump_next;
    logic                    m_touch_reg, m_touch_next;

    logic [ALPHA_W-1:0]                 alpha_eff;
    logic signed [SMOOTH_W:0]           diff;
    logic signed [ALPHA_W+SMOOTH_W+1:0] prod;
    logic signed [ALPHA_W+SMOOTH_W+1:0] prod_sh;
    logic signed [COORD_BITS:0]         rise;
    logic signed [COORD_BITS:0]         step;
    logic signed [COORD_BITS:0]         rel_rise;
    logic signed [SMOOTH_W:0]           dx;
    logic [SMOOTH_W:0]                  dx_abs;
    logic [SMOOTH_W-1:0]                dz;
    logic [SMOOTH_W-1:0]                mag;
    logic [Q14_BITS:0]                  sat;
    logic [MOVE_W-1:0]                  sat_ext;

    tdjq_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_out   (cfg)
    );

    tdjq_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cfg.span),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);

    always_comb begin
        alpha_eff = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
        diff      = $signed({1'b0, x_reg, {ALPHA_FRAC_BITS{1'b0}}})
                  - $signed({1'b0, smooth_reg});
        prod      = $signed({2'b00, alpha_eff}) * diff;
        prod_sh   = prod >>> ALPHA_FRAC_BITS;
        rise      = $signed({1'b0, anchor_y_reg}) - $signed({1'b0, y_reg});
        step      = $signed({1'b0, last_y_reg}) - $signed({1'b0, y_reg});
        rel_rise  = $signed({1'b0, anchor_y_reg}) - $signed({1'b0, prior_y_reg});
        dx        = $signed({1'b0, smooth_reg})
                  - $signed({1'b0, anchor_x_reg, {ALPHA_FRAC_BITS{1'b0}}});
        dx_abs    = dx[SMOOTH_W] ? (-dx) : dx;
        dz        = {cfg.dead_zone, {ALPHA_FRAC_BITS{1'b0}}};
        mag       = dx_abs[SMOOTH_W-1:0] - dz;
        sat       = (div_quo > Q14_ONE) ? Q14_ONE[Q14_BITS:0] : div_quo[Q14_BITS:0];
        sat_ext   = MOVE_W'(sat);
    end

    always_comb begin
        state_next    = state_reg;
        touch_next    = touch_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        was_next      = was_reg;
        anchor_x_next = anchor_x_reg;
        anchor_y_next = anchor_y_reg;
        smooth_next   = smooth_reg;
        last_y_next   = last_y_reg;
        prior_y_next  = prior_y_reg;
        armed_next    = armed_reg;
        held_next     = held_reg;
        jump_next     = jump_reg;
        neg_next      = neg_reg;
        zero_next     = zero_reg;
        m_valid_next  = m_valid_reg;
        m_move_next   = m_move_reg;
        m_jump_next   = m_jump_reg;
        m_touch_next  = m_touch_reg;
        div_start     = 1'b0;
        div_dividend  = {mag, {Q_SHIFT{1'b0}}};

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    touch_next = s_touch_present;
                    x_next     = s_sample_x;
                    y_next     = s_sample_y;
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                jump_next = 1'b0;
                held_next = 1'b0;
                if (touch_reg && !was_reg) begin
                    anchor_x_next = x_reg;
                    anchor_y_next = y_reg;
                    smooth_next   = {x_reg, {ALPHA_FRAC_BITS{1'b0}}};
                    last_y_next   = y_reg;
                    prior_y_next  = y_reg;
                    armed_next    = 1'b1;
                end else if (touch_reg) begin
                    smooth_next  = smooth_reg + prod_sh[SMOOTH_W-1:0];
                    prior_y_next = last_y_reg;
                    last_y_next  = y_reg;
                    held_next    = 1'b1;
                    // A firing sample does not re-arm in the same transaction.
                    if (armed_reg && (rise > $signed({1'b0, cfg.flick})
                                   || step > $signed({1'b0, cfg.velocity}))) begin
                        jump_next  = 1'b1;
                        armed_next = 1'b0;
                    end else if (!armed_reg && rise < $signed({1'b0, cfg.rearm})) begin
                        armed_next = 1'b1;
                    end
                end else if (was_reg) begin
                    jump_next = armed_reg && (rel_rise > $signed({1'b0, cfg.flick}));
                end
                was_next   = touch_reg;
                state_next = ST_DZ;
            end
            ST_DZ: begin
                neg_next = dx[SMOOTH_W];
                if (held_reg && (dx_abs[SMOOTH_W-1:0] > dz)) begin
                    zero_next  = 1'b0;
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    zero_next  = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_jump_next  = jump_reg;
                    m_touch_next = touch_reg;
                    if (zero_reg) begin
                        m_move_next = '0;
                    end else if (neg_reg) begin
                        m_move_next = -sat_ext;
                    end else begin
                        m_move_next = sat_ext;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            was_reg      <= 1'b0;
            anchor_x_reg <= '0;
            anchor_y_reg <= '0;
            smooth_reg   <= '0;
            last_y_reg   <= '0;
            prior_y_reg  <= '0;
            armed_reg    <= 1'b1;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            was_reg      <= was_next;
            anchor_x_reg <= anchor_x_next;
            anchor_y_reg <= anchor_y_next;
            smooth_reg   <= smooth_next;
            last_y_reg   <= last_y_next;
            prior_y_reg  <= prior_y_next;
            armed_reg    <= armed_next;
            m_valid_reg  <= m_valid_next;
        end
        touch_reg   <= touch_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        held_reg    <= held_next;
        jump_reg    <= jump_next;
        neg_reg     <= neg_next;
        zero_reg    <= zero_next;
        m_move_reg  <= m_move_next;
        m_jump_reg  <= m_jump_next;
        m_touch_reg <= m_touch_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_move_x       = m_move_reg;
    assign m_jump_pulse   = m_jump_reg;
    assign m_touch_active = m_touch_reg;

endmodule

// File: sv/tdjq_checker.sv
// ============================================================================
// Port checker
// Watches the top level's ports for handshake and result consistency.
// ============================================================================
module tdjq_checker
    import tdjq_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [MOVE_W-1:0]     m_move_x,
    input logic                  m_jump_pulse,
    input logic                  m_touch_active
);

    // A stalled result keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_move_x)
            && $stable(m_jump_pulse) && $stable(m_touch_active))
        else $error("stalled result changed");

    // The block works on one transaction at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    // Without a touch there is no deflection.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_touch_active |-> m_move_x == '0)
        else $error("deflection without touch");

    // The deflection never exceeds plus or minus one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_move_x) <= $signed(MOVE_W'(1 << Q14_BITS))
                  && $signed(m_move_x) >= -$signed(MOVE_W'(1 << Q14_BITS))))
        else $error("deflection out of range");

endmodule

bind touch_drag_joystick_qualifier_top tdjq_checker u_tdjq_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_move_x       (m_move_x),
    .m_jump_pulse   (m_jump_pulse),
    .m_touch_active (m_touch_active)
);
